/* rtl/core/mfsc_pkg.sv */
// ----------------------------------------------------------------------------
// mfsc_pkg
// shared types, register indexes and md5 round tables for the feedback cipher
// ----------------------------------------------------------------------------
package mfsc_pkg;

	typedef struct packed {
		logic        kind;
		logic [63:0] data_block;
		logic        last_block;
	} in_item_t;

	typedef struct packed {
		logic [63:0] out_block;
		logic        is_header;
		logic        out_last;
	} out_item_t;

	// classified item handed from the front to the back
	typedef struct packed {
		logic        is_start;
		logic        is_last;
		logic [63:0] block;
	} op_t;

	// front to back channel
	typedef struct packed {
		logic valid;
		op_t  op;
	} op_chan_t;

	// back status seen by the top level
	typedef struct packed {
		logic engine_busy;
		logic engine_done;
	} back_status_t;

	localparam logic KIND_START = 1'b0;

	localparam logic [1:0] REG_KEY_FIRST  = 2'd0;
	localparam logic [1:0] REG_KEY_SECOND = 2'd1;
	localparam logic [1:0] REG_DECRYPT    = 2'd2;

	localparam logic [1:0] QUEUE_DEPTH = 2'd2;

	localparam logic [31:0] MD5_A0 = 32'h67452301;
	localparam logic [31:0] MD5_B0 = 32'hefcdab89;
	localparam logic [31:0] MD5_C0 = 32'h98badcfe;
	localparam logic [31:0] MD5_D0 = 32'h10325476;
	localparam logic [31:0] MD5_PAD_WORD = 32'h00000080;
	localparam logic [31:0] MD5_LEN_WORD = 32'd128;

	function automatic logic [31:0] bswap32(input logic [31:0] x);
		bswap32 = {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	function automatic logic [4:0] md5_shift(input logic [3:0] idx);
		unique case (idx)
			4'd0:  md5_shift = 5'd7;
			4'd1:  md5_shift = 5'd12;
			4'd2:  md5_shift = 5'd17;
			4'd3:  md5_shift = 5'd22;
			4'd4:  md5_shift = 5'd5;
			4'd5:  md5_shift = 5'd9;
			4'd6:  md5_shift = 5'd14;
			4'd7:  md5_shift = 5'd20;
			4'd8:  md5_shift = 5'd4;
			4'd9:  md5_shift = 5'd11;
			4'd10: md5_shift = 5'd16;
			4'd11: md5_shift = 5'd23;
			4'd12: md5_shift = 5'd6;
			4'd13: md5_shift = 5'd10;
			4'd14: md5_shift = 5'd15;
			default: md5_shift = 5'd21;
		endcase
	endfunction

	function automatic logic [31:0] md5_k(input logic [5:0] i);
		unique case (i)
			6'd0:  md5_k = 32'hd76aa478;  6'd1:  md5_k = 32'he8c7b756;
			6'd2:  md5_k = 32'h242070db;  6'd3:  md5_k = 32'hc1bdceee;
			6'd4:  md5_k = 32'hf57c0faf;  6'd5:  md5_k = 32'h4787c62a;
			6'd6:  md5_k = 32'ha8304613;  6'd7:  md5_k = 32'hfd469501;
			6'd8:  md5_k = 32'h698098d8;  6'd9:  md5_k = 32'h8b44f7af;
			6'd10: md5_k = 32'hffff5bb1;  6'd11: md5_k = 32'h895cd7be;
			6'd12: md5_k = 32'h6b901122;  6'd13: md5_k = 32'hfd987193;
			6'd14: md5_k = 32'ha679438e;  6'd15: md5_k = 32'h49b40821;
			6'd16: md5_k = 32'hf61e2562;  6'd17: md5_k = 32'hc040b340;
			6'd18: md5_k = 32'h265e5a51;  6'd19: md5_k = 32'he9b6c7aa;
			6'd20: md5_k = 32'hd62f105d;  6'd21: md5_k = 32'h02441453;
			6'd22: md5_k = 32'hd8a1e681;  6'd23: md5_k = 32'he7d3fbc8;
			6'd24: md5_k = 32'h21e1cde6;  6'd25: md5_k = 32'hc33707d6;
			6'd26: md5_k = 32'hf4d50d87;  6'd27: md5_k = 32'h455a14ed;
			6'd28: md5_k = 32'ha9e3e905;  6'd29: md5_k = 32'hfcefa3f8;
			6'd30: md5_k = 32'h676f02d9;  6'd31: md5_k = 32'h8d2a4c8a;
			6'd32: md5_k = 32'hfffa3942;  6'd33: md5_k = 32'h8771f681;
			6'd34: md5_k = 32'h6d9d6122;  6'd35: md5_k = 32'hfde5380c;
			6'd36: md5_k = 32'ha4beea44;  6'd37: md5_k = 32'h4bdecfa9;
			6'd38: md5_k = 32'hf6bb4b60;  6'd39: md5_k = 32'hbebfbc70;
			6'd40: md5_k = 32'h289b7ec6;  6'd41: md5_k = 32'heaa127fa;
			6'd42: md5_k = 32'hd4ef3085;  6'd43: md5_k = 32'h04881d05;
			6'd44: md5_k = 32'hd9d4d039;  6'd45: md5_k = 32'he6db99e5;
			6'd46: md5_k = 32'h1fa27cf8;  6'd47: md5_k = 32'hc4ac5665;
			6'd48: md5_k = 32'hf4292244;  6'd49: md5_k = 32'h432aff97;
			6'd50: md5_k = 32'hab9423a7;  6'd51: md5_k = 32'hfc93a039;
			6'd52: md5_k = 32'h655b59c3;  6'd53: md5_k = 32'h8f0ccc92;
			6'd54: md5_k = 32'hffeff47d;  6'd55: md5_k = 32'h85845dd1;
			6'd56: md5_k = 32'h6fa87e4f;  6'd57: md5_k = 32'hfe2ce6e0;
			6'd58: md5_k = 32'ha3014314;  6'd59: md5_k = 32'h4e0811a1;
			6'd60: md5_k = 32'hf7537e82;  6'd61: md5_k = 32'hbd3af235;
			6'd62: md5_k = 32'h2ad7d2bb;  default: md5_k = 32'heb86d391;
		endcase
	endfunction

endpackage

/* rtl/core/mfsc_md5.sv */
// ----------------------------------------------------------------------------
// mfsc_md5
// iterative md5 of a 16 byte message, one round per cycle
// ----------------------------------------------------------------------------
module mfsc_md5 (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [63:0]   first,
	input  logic [63:0]   second,
	output logic          busy,
	output logic          done,
	output logic [127:0]  digest
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [63:0] first_q, second_q;

	logic [1:0]  rnd;
	logic [3:0]  i4;
	logic [31:0] f;
	logic [3:0]  g;
	logic [31:0] mword;
	logic [31:0] sum;
	logic [4:0]  sh;
	logic [63:0] rot_wide;
	logic [31:0] new_b;

	assign rnd = cnt_q[5:4];
	assign i4  = cnt_q[3:0];
	assign sh  = mfsc_pkg::md5_shift({rnd, cnt_q[1:0]});

	always_comb begin
		unique case (rnd)
			2'd0: begin
				f = (b_q & c_q) | (~b_q & d_q);
				g = i4;
			end
			2'd1: begin
				f = (d_q & b_q) | (~d_q & c_q);
				g = 4'(i4 * 4'd5 + 4'd1);
			end
			2'd2: begin
				f = b_q ^ c_q ^ d_q;
				g = 4'(i4 * 4'd3 + 4'd5);
			end
			default: begin
				f = c_q ^ (b_q | ~d_q);
				g = 4'(i4 * 4'd7);
			end
		endcase
	end

	// message: key half, data half, padding byte, bit length
	always_comb begin
		case (g)
			4'd0:    mword = mfsc_pkg::bswap32(first_q[63:32]);
			4'd1:    mword = mfsc_pkg::bswap32(first_q[31:0]);
			4'd2:    mword = mfsc_pkg::bswap32(second_q[63:32]);
			4'd3:    mword = mfsc_pkg::bswap32(second_q[31:0]);
			4'd4:    mword = mfsc_pkg::MD5_PAD_WORD;
			4'd14:   mword = mfsc_pkg::MD5_LEN_WORD;
			default: mword = 32'd0;
		endcase
	end

	assign sum      = a_q + f + mfsc_pkg::md5_k(cnt_q) + mword;
	assign rot_wide = {sum, sum} << sh;
	assign new_b    = b_q + rot_wide[63:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q      <= mfsc_pkg::MD5_A0;
			b_q      <= mfsc_pkg::MD5_B0;
			c_q      <= mfsc_pkg::MD5_C0;
			d_q      <= mfsc_pkg::MD5_D0;
			first_q  <= first;
			second_q <= second;
		end else if (busy_q) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= new_b;
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign digest = {mfsc_pkg::bswap32(a_q + mfsc_pkg::MD5_A0),
	                 mfsc_pkg::bswap32(b_q + mfsc_pkg::MD5_B0),
	                 mfsc_pkg::bswap32(c_q + mfsc_pkg::MD5_C0),
	                 mfsc_pkg::bswap32(d_q + mfsc_pkg::MD5_D0)};

endmodule

/* rtl/core/mfsc_front.sv */
// ----------------------------------------------------------------------------
// mfsc_front
// input queue that accepts items and classifies them for the back end
// ----------------------------------------------------------------------------
module mfsc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  mfsc_pkg::in_item_t  item,
	output mfsc_pkg::op_chan_t  op_chan,
	input  logic                op_take
);

	mfsc_pkg::in_item_t mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;
	mfsc_pkg::in_item_t head;

	assign full    = (cnt_q == mfsc_pkg::QUEUE_DEPTH);
	assign do_push = push && !full;
	assign do_pop  = op_take && (cnt_q != 2'd0);
	assign head    = mem_q[rd_q];

	always_comb begin
		op_chan.valid       = (cnt_q != 2'd0);
		op_chan.op.is_start = (head.kind == mfsc_pkg::KIND_START);
		op_chan.op.is_last  = head.last_block;
		op_chan.op.block    = head.data_block;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= item;
	end

endmodule

/* rtl/core/mfsc_back.sv */
// ----------------------------------------------------------------------------
// mfsc_back
// message state, keystream chaining and result queue
// ----------------------------------------------------------------------------
module mfsc_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mfsc_pkg::op_chan_t     op_chan,
	output logic                   op_take,
	input  logic [63:0]            key_first,
	input  logic [63:0]            key_second,
	input  logic                   decrypt,
	output mfsc_pkg::out_item_t    result,
	output logic                   empty,
	input  logic                   pop,
	output mfsc_pkg::back_status_t status
);

	logic        open_q;
	logic [63:0] stream_q, feedback_q;

	logic         eng_start, eng_busy, eng_done;
	logic [63:0]  eng_second;
	logic [127:0] eng_digest;

	mfsc_pkg::out_item_t res_mem_q [2];
	logic       res_wr_q, res_rd_q;
	logic [1:0] res_cnt_q;
	logic       res_push, res_pop;
	mfsc_pkg::out_item_t res_item;
	mfsc_pkg::op_t op;

	mfsc_md5 u_md5 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (eng_start),
		.first  (key_second),
		.second (eng_second),
		.busy   (eng_busy),
		.done   (eng_done),
		.digest (eng_digest)
	);

	assign op      = op_chan.op;
	assign op_take = op_chan.valid && !eng_busy && !eng_done
	                 && (res_cnt_q != mfsc_pkg::QUEUE_DEPTH);

	always_comb begin
		eng_start  = 1'b0;
		eng_second = feedback_q;
		res_push   = 1'b0;
		res_item   = '{out_block: op.block ^ stream_q, is_header: 1'b0,
		               out_last: op.is_last};
		if (op_take) begin
			if (op.is_start) begin
				eng_start  = 1'b1;
				eng_second = decrypt ? (op.block ^ key_first) : op.block;
				res_push   = !decrypt;
				res_item   = '{out_block: op.block ^ key_first, is_header: 1'b1,
				               out_last: 1'b0};
			end else if (open_q) begin
				res_push  = 1'b1;
				eng_start = !op.is_last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q     <= 1'b0;
			stream_q   <= 64'd0;
			feedback_q <= 64'd0;
		end else begin
			if (eng_done) begin
				stream_q   <= eng_digest[127:64];
				feedback_q <= eng_digest[63:0];
			end
			if (op_take) begin
				if (op.is_start) begin
					open_q <= 1'b1;
				end else if (open_q && op.is_last) begin
					// final block closes the message and wipes the chain
					open_q     <= 1'b0;
					stream_q   <= 64'd0;
					feedback_q <= 64'd0;
				end
			end
		end
	end

	assign res_pop = pop && (res_cnt_q != 2'd0);
	assign empty   = (res_cnt_q == 2'd0);
	assign result  = res_mem_q[res_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= 1'b0;
			res_rd_q  <= 1'b0;
			res_cnt_q <= 2'd0;
		end else begin
			if (res_push) res_wr_q <= ~res_wr_q;
			if (res_pop)  res_rd_q <= ~res_rd_q;
			res_cnt_q <= res_cnt_q + 2'(res_push) - 2'(res_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) res_mem_q[res_wr_q] <= res_item;
	end

	assign status = '{engine_busy: eng_busy, engine_done: eng_done};

endmodule

/* rtl/core/md5_feedback_stream_cipher.sv */
// ----------------------------------------------------------------------------
// md5_feedback_stream_cipher
// md5 output feedback stream cipher over 8 byte blocks
// ----------------------------------------------------------------------------
// items enter through push/full and leave through empty/pop; both sides are
// two-entry queues, so input is taken while a result waits to be popped.
// a start item carries the nonce (encrypt) or the header block (decrypt);
// in encrypt mode it yields the header result, in decrypt mode nothing.
// each data block of an open message yields one result; data outside a
// message is dropped.
// every start and every non-final data block of an open message runs one md5
// compression in the shared round engine: a load, 64 rounds at one per cycle
// and a fold of the digest into the chain; the back end takes no new item
// until the engine is idle and its digest folded in. the first result of an
// item accepted into an idle block passes from the input queue into the result
// queue before it shows on result. reset clears the queues, the keys, the
// mode and the message state. when pop stays low the result queue fills, the
// back end stops taking items and full rises once the input queue holds two
// items. configuration is written through cfg_wr_en/cfg_index/cfg_wdata by
// the user only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module md5_feedback_stream_cipher (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_index,
	input  logic [63:0]         cfg_wdata,
	input  logic                push,
	output logic                full,
	input  mfsc_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output mfsc_pkg::out_item_t result
);

	logic [63:0] key_first_q, key_second_q;
	logic        decrypt_q;
	mfsc_pkg::op_chan_t     op_chan;
	logic                   op_take;
	mfsc_pkg::back_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_first_q  <= 64'd0;
			key_second_q <= 64'd0;
			decrypt_q    <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				mfsc_pkg::REG_KEY_FIRST:  key_first_q  <= cfg_wdata;
				mfsc_pkg::REG_KEY_SECOND: key_second_q <= cfg_wdata;
				mfsc_pkg::REG_DECRYPT:    decrypt_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	mfsc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.op_chan (op_chan),
		.op_take (op_take)
	);

	mfsc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_chan    (op_chan),
		.op_take    (op_take),
		.key_first  (key_first_q),
		.key_second (key_second_q),
		.decrypt    (decrypt_q),
		.result     (result),
		.empty      (empty),
		.pop        (pop),
		.status     (status)
	);

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		op_take |-> op_chan.valid)
		else $error("back took an item the front did not offer");

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		op_take |-> !status.engine_busy && !status.engine_done)
		else $error("item taken while the md5 engine was running");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		status.engine_done |-> $past(status.engine_busy))
		else $error("md5 done without a running compression");

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// checks md5_feedback_stream_cipher against an in-bench md5 feedback predictor
// ----------------------------------------------------------------------------
// the bench writes keys and the mode while the block is idle. it pushes start
// and data items and compares every popped result with the predicted queue.
// ----------------------------------------------------------------------------
module tb;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_wdata;
	logic        push;
	logic        full;
	mfsc_pkg::in_item_t  item;
	logic        empty;
	logic        pop;
	mfsc_pkg::out_item_t result;

	md5_feedback_stream_cipher dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result)
	);

	// predictor state
	logic [63:0] key_lo, key_hi;
	logic        decrypt;
	logic [63:0] keystream, chain_half;
	logic        msg_open;

	mfsc_pkg::in_item_t  pending_items[$];
	mfsc_pkg::out_item_t cipher_results[$];
	int        error_count;
	int        cycle_count;
	bit        quiet;
	int        push_gap, pop_gap;
	logic      full_seen;

	localparam int LIMIT = 600000;

	localparam logic [31:0] ROUND_K[64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
		32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
		32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
		32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
		32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
		32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};
	localparam int ROT[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

	function automatic logic [31:0] le_word(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	// digest of the 16 bytes hi_part || lo_part, returned as bytes 0..15
	function automatic logic [127:0] digest16(input logic [63:0] hi_part,
		input logic [63:0] lo_part);
		logic [31:0] w[16];
		logic [31:0] a, b, c, d, f, t, sum;
		int g, r;
		for (int j = 0; j < 16; j++) w[j] = '0;
		w[0] = le_word(hi_part[63:32]);
		w[1] = le_word(hi_part[31:0]);
		w[2] = le_word(lo_part[63:32]);
		w[3] = le_word(lo_part[31:0]);
		w[4] = 32'h80;
		w[14] = 32'd128;
		a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
		for (int i = 0; i < 64; i++) begin
			r = i >> 4;
			case (r)
				0: begin f = (b & c) | (~b & d); g = i; end
				1: begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
				2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
				default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
			endcase
			sum = a + f + ROUND_K[i] + w[g];
			t = d; d = c; c = b;
			b = b + ((sum << ROT[r * 4 + i % 4]) | (sum >> (32 - ROT[r * 4 + i % 4])));
			a = t;
		end
		a += 32'h67452301; b += 32'hefcdab89; c += 32'h98badcfe; d += 32'h10325476;
		return {le_word(a), le_word(b), le_word(c), le_word(d)};
	endfunction

	function automatic void predict_cipher(input mfsc_pkg::in_item_t it);
		mfsc_pkg::out_item_t res;
		logic [127:0] dg;
		if (it.kind == mfsc_pkg::KIND_START) begin
			if (!decrypt) begin
				res.out_block = it.data_block ^ key_lo;
				res.is_header = 1'b1;
				res.out_last = 1'b0;
				cipher_results.push_back(res);
				dg = digest16(key_hi, it.data_block);
			end else begin
				dg = digest16(key_hi, it.data_block ^ key_lo);
			end
			{keystream, chain_half} = dg;
			msg_open = 1'b1;
		end else if (msg_open) begin
			res.out_block = it.data_block ^ keystream;
			res.is_header = 1'b0;
			res.out_last = it.last_block;
			cipher_results.push_back(res);
			if (it.last_block) begin
				keystream = '0; chain_half = '0; msg_open = 1'b0;
			end else begin
				{keystream, chain_half} = digest16(key_hi, chain_half);
			end
		end
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			mfsc_pkg::REG_KEY_FIRST: key_lo = val;
			mfsc_pkg::REG_KEY_SECOND: key_hi = val;
			default: decrypt = val[0];
		endcase
	endtask

	function automatic mfsc_pkg::in_item_t make_item(input logic k, input logic [63:0] blk,
		input logic lst);
		mfsc_pkg::in_item_t it;
		it.kind = k;
		it.data_block = blk;
		it.last_block = lst;
		return it;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// wait until all queued items went in and all results came out
	task automatic drain();
		while (pending_items.size() != 0 || cipher_results.size() != 0 || push)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > LIMIT) begin
				$display("md5_feedback_stream_cipher: mismatch");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		full_seen <= full;
		if (push && !full) begin
			predict_cipher(item);
		end
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!push || !full_seen) begin
				if (push_gap > 0) begin
					push_gap <= push_gap - 1;
					push <= 1'b0;
				end else if (pending_items.size() != 0) begin
					item <= pending_items.pop_front();
					push <= 1'b1;
					if (!quiet && $urandom_range(0, 5) == 0) push_gap <= $urandom_range(1, 9);
				end else begin
					push <= 1'b0;
				end
			end
			if (pop_gap > 0) begin
				pop_gap <= pop_gap - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				if (!quiet && $urandom_range(0, 7) == 0) pop_gap <= $urandom_range(1, 9);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		mfsc_pkg::out_item_t want;
		if (pop && !empty) begin
			if (cipher_results.size() == 0) begin
				$display("%0t: result expected none actual %h", $time, result);
				error_count++;
			end else begin
				want = cipher_results.pop_front();
				if (result.out_block !== want.out_block) begin
					$display("%0t: out_block expected %h actual %h", $time,
						want.out_block, result.out_block);
					error_count++;
				end
				if (result.is_header !== want.is_header) begin
					$display("%0t: is_header expected %b actual %b", $time,
						want.is_header, result.is_header);
					error_count++;
				end
				if (result.out_last !== want.out_last) begin
					$display("%0t: out_last expected %b actual %b", $time,
						want.out_last, result.out_last);
					error_count++;
				end
			end
		end
	end

	task automatic queue_message(input int n_data);
		pending_items.push_back(make_item(mfsc_pkg::KIND_START, rand64(),
			1'($urandom_range(0, 1))));
		for (int j = 0; j < n_data; j++)
			pending_items.push_back(make_item(1'b1, rand64(), j == n_data - 1));
	endtask

	initial begin
		int sent, n;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0; cfg_index = '0; cfg_wdata = '0;
		push = 1'b0; pop = 1'b0; item = '0;
		key_lo = '0; key_hi = '0; decrypt = 1'b0;
		keystream = '0; chain_half = '0; msg_open = 1'b0;
		error_count = 0; quiet = 1'b0; push_gap = 0; pop_gap = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset keys, data with no open message, extremes
		pending_items.push_back(make_item(1'b1, 64'h1234, 1'b0));
		pending_items.push_back(make_item(mfsc_pkg::KIND_START, '0, 1'b0));
		pending_items.push_back(make_item(1'b1, '0, 1'b0));
		pending_items.push_back(make_item(1'b1, '1, 1'b0));
		pending_items.push_back(make_item(mfsc_pkg::KIND_START, '1, 1'b1));
		pending_items.push_back(make_item(1'b1, 64'h0123456789abcdef, 1'b1));
		pending_items.push_back(make_item(1'b1, '1, 1'b1));
		drain();
		write_reg(mfsc_pkg::REG_KEY_FIRST, '1);
		write_reg(mfsc_pkg::REG_KEY_SECOND, '1);
		write_reg(mfsc_pkg::REG_DECRYPT, 64'd1);
		pending_items.push_back(make_item(mfsc_pkg::KIND_START, '0, 1'b0));
		pending_items.push_back(make_item(1'b1, '1, 1'b0));
		pending_items.push_back(make_item(mfsc_pkg::KIND_START, '1, 1'b0));
		pending_items.push_back(make_item(1'b1, '0, 1'b1));
		pending_items.push_back(make_item(1'b1, '0, 1'b0));
		drain();

		sent = 0;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin
					write_reg(mfsc_pkg::REG_KEY_FIRST, rand64());
					write_reg(mfsc_pkg::REG_KEY_SECOND, rand64());
				end
				1: begin
					write_reg(mfsc_pkg::REG_KEY_FIRST, '0);
					write_reg(mfsc_pkg::REG_KEY_SECOND, '1);
				end
				2: begin
					write_reg(mfsc_pkg::REG_KEY_FIRST, '1);
					write_reg(mfsc_pkg::REG_KEY_SECOND, '0);
				end
				default: write_reg(mfsc_pkg::REG_KEY_SECOND, rand64());
			endcase
			write_reg(mfsc_pkg::REG_DECRYPT, {63'd0, 1'($urandom_range(0, 1))});
			if (ph == 7) quiet = 1'b1;
			while (sent < (ph + 1) * 56) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise: stray data or an unfinished message
					pending_items.push_back(make_item(1'($urandom_range(0, 1)), rand64(),
						1'($urandom_range(0, 1))));
					sent++;
				end else begin
					n = $urandom_range(0, 6);
					queue_message(n);
					sent += n + 1;
				end
			end
			drain();
		end

		if (error_count == 0)
			$display("md5_feedback_stream_cipher: match");
		else
			$display("md5_feedback_stream_cipher: mismatch");
		$finish;
	end
endmodule

/* sim.f */
rtl/core/mfsc_pkg.sv
rtl/core/mfsc_md5.sv
rtl/core/mfsc_front.sv
rtl/core/mfsc_back.sv
rtl/core/md5_feedback_stream_cipher.sv
dv/tb.sv
